// ===== hw/rtl/via_pkg.sv =====
// ----------------------------------------------------------------------------
// via_pkg: shared types and constants for the interface adapter
// Operation codes, register offsets, interrupt flag masks, the item type and merge_port.
// ----------------------------------------------------------------------------
package via_pkg;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_TICK  = 2'd2,
		OP_KEY   = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		RG_ORB   = 4'd0,
		RG_ORA   = 4'd1,
		RG_DDRB  = 4'd2,
		RG_DDRA  = 4'd3,
		RG_T1CL  = 4'd4,
		RG_T1CH  = 4'd5,
		RG_T1LL  = 4'd6,
		RG_T1LH  = 4'd7,
		RG_T2CL  = 4'd8,
		RG_T2CH  = 4'd9,
		RG_SR    = 4'd10,
		RG_ACR   = 4'd11,
		RG_PCR   = 4'd12,
		RG_IFR   = 4'd13,
		RG_IER   = 4'd14,
		RG_ORANH = 4'd15
	} reg_t;

	localparam logic [6:0] FLAG_CA  = 7'h03;
	localparam logic [6:0] FLAG_SR  = 7'h04;
	localparam logic [6:0] FLAG_CB  = 7'h18;
	localparam logic [6:0] FLAG_CB1 = 7'h10;
	localparam logic [6:0] FLAG_T1  = 7'h40;

	localparam logic [2:0] CB2_KEY_ON  = 3'd6;
	localparam logic [2:0] CB2_KEY_OFF = 3'd7;

	localparam logic [7:0]  LINES_IDLE  = 8'hFF;
	localparam logic [15:0] TIMER_RESET = 16'hFFFF;

	typedef struct packed {
		op_t        op;
		logic [3:0] reg_addr;
		logic [7:0] write_data;
		logic [7:0] key_code;
	} item_t;

	function automatic logic [7:0] merge_port(input logic [7:0] dir,
			input logic [7:0] drive, input logic [7:0] lines);
		return (dir & drive) | (~dir & lines);
	endfunction

endpackage

// ===== hw/rtl/via_core.sv =====
// ----------------------------------------------------------------------------
// via_core: register file and step logic
// Holds all adapter state and applies one item when fire is high; returns
// the read byte from the prior state and irq as it stands after that item.
// ----------------------------------------------------------------------------
module via_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  via_pkg::item_t item,
	output logic [7:0]     read_data,
	output logic           irq
);
	import via_pkg::*;

	logic [7:0]  port_b_out_q, port_a_out_q, port_b_dir_q, port_a_dir_q;
	logic [15:0] t1_count_q, t1_latch_q;
	logic [7:0]  t2_low_q, t2_high_q, shift_q, acr_q, pcr_q;
	logic [6:0]  flags_q, enable_q;
	logic        t1_active_q, key_en_q, key_pend_q;
	logic [7:0]  key_byte_q;

	logic [7:0]  port_b_out_n, port_a_out_n, port_b_dir_n, port_a_dir_n;
	logic [15:0] t1_count_n, t1_latch_n, t1_dec;
	logic [7:0]  t2_low_n, t2_high_n, shift_n, acr_n, pcr_n;
	logic [6:0]  flags_n, enable_n;
	logic        t1_active_n, key_en_n, key_pend_n;
	logic [7:0]  key_byte_n;
	logic        shown, summary;

	assign shown   = key_en_q && key_pend_q;
	assign summary = |(flags_q & enable_q);
	assign t1_dec  = t1_count_q - 16'd1;

	always_comb begin
		port_b_out_n = port_b_out_q;
		port_a_out_n = port_a_out_q;
		port_b_dir_n = port_b_dir_q;
		port_a_dir_n = port_a_dir_q;
		t1_count_n   = t1_count_q;
		t1_latch_n   = t1_latch_q;
		t2_low_n     = t2_low_q;
		t2_high_n    = t2_high_q;
		shift_n      = shift_q;
		acr_n        = acr_q;
		pcr_n        = pcr_q;
		flags_n      = flags_q;
		enable_n     = enable_q;
		t1_active_n  = t1_active_q;
		key_en_n     = key_en_q;
		key_pend_n   = key_pend_q;
		key_byte_n   = key_byte_q;
		read_data    = '0;
		unique case (item.op)
			OP_READ: begin
				unique case (reg_t'(item.reg_addr))
					RG_ORB: begin
						flags_n   = flags_q & ~FLAG_CB;
						read_data = merge_port(port_b_dir_q, port_b_out_q,
							shown ? key_byte_q : LINES_IDLE);
						if (shown)
							key_pend_n = 1'b0;
					end
					RG_ORA: begin
						flags_n   = flags_q & ~FLAG_CA;
						read_data = merge_port(port_a_dir_q, port_a_out_q, LINES_IDLE);
					end
					RG_DDRB: read_data = port_b_dir_q;
					RG_DDRA: read_data = port_a_dir_q;
					RG_T1CL: begin
						flags_n   = flags_q & ~FLAG_T1;
						read_data = t1_count_q[7:0];
					end
					RG_T1CH:  read_data = t1_count_q[15:8];
					RG_T1LL:  read_data = t1_latch_q[7:0];
					RG_T1LH:  read_data = t1_latch_q[15:8];
					RG_T2CL:  read_data = t2_low_q;
					RG_T2CH:  read_data = t2_high_q;
					RG_SR:    read_data = shift_q;
					RG_ACR:   read_data = acr_q;
					RG_PCR:   read_data = pcr_q;
					RG_IFR:   read_data = {summary, flags_q};
					RG_IER:   read_data = {1'b1, enable_q};
					RG_ORANH: read_data = merge_port(port_a_dir_q, port_a_out_q, LINES_IDLE);
					default:  read_data = '0;
				endcase
			end
			OP_WRITE: begin
				unique case (reg_t'(item.reg_addr))
					RG_ORB: begin
						flags_n      = flags_q & ~FLAG_CB;
						port_b_out_n = item.write_data;
					end
					RG_ORA: begin
						flags_n      = flags_q & ~FLAG_CA;
						port_a_out_n = item.write_data;
					end
					RG_DDRB: port_b_dir_n = item.write_data;
					RG_DDRA: port_a_dir_n = item.write_data;
					RG_T1CL, RG_T1LL: t1_latch_n = {t1_latch_q[15:8], item.write_data};
					RG_T1CH: begin
						t1_latch_n  = {item.write_data, t1_latch_q[7:0]};
						t1_count_n  = {item.write_data, t1_latch_q[7:0]};
						flags_n     = flags_q & ~FLAG_T1;
						t1_active_n = 1'b1;
					end
					RG_T1LH: begin
						t1_latch_n = {item.write_data, t1_latch_q[7:0]};
						flags_n    = flags_q & ~FLAG_T1;
					end
					RG_T2CL: t2_low_n  = item.write_data;
					RG_T2CH: t2_high_n = item.write_data;
					RG_SR: begin
						shift_n = item.write_data;
						flags_n = flags_q & ~FLAG_SR;
					end
					RG_ACR: acr_n = item.write_data;
					RG_PCR: begin
						pcr_n = item.write_data;
						if (item.write_data[7:5] == CB2_KEY_ON)
							key_en_n = 1'b1;
						else if (item.write_data[7:5] == CB2_KEY_OFF)
							key_en_n = 1'b0;
					end
					RG_IFR: flags_n = flags_q & ~item.write_data[6:0];
					RG_IER: begin
						if (item.write_data[7])
							enable_n = enable_q | item.write_data[6:0];
						else
							enable_n = enable_q & ~item.write_data[6:0];
					end
					RG_ORANH: port_a_out_n = item.write_data;
					default:  port_a_out_n = port_a_out_q;
				endcase
			end
			OP_TICK: begin
				if (t1_active_q && (t1_count_q != '0)) begin
					if (t1_dec == '0) begin
						flags_n = flags_n | FLAG_T1;
						if (acr_q[6])
							t1_count_n = t1_latch_q;
						else begin
							t1_count_n  = t1_dec;
							t1_active_n = 1'b0;
						end
					end else begin
						t1_count_n = t1_dec;
					end
				end
				if (shown)
					flags_n = flags_n | FLAG_CB1;
			end
			OP_KEY: begin
				key_byte_n = item.key_code;
				key_pend_n = 1'b1;
			end
			default: key_pend_n = key_pend_q;
		endcase
	end

	assign irq = |(flags_n & enable_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_b_out_q <= '0;
			port_a_out_q <= '0;
			port_b_dir_q <= '0;
			port_a_dir_q <= '0;
			t1_count_q   <= TIMER_RESET;
			t1_latch_q   <= TIMER_RESET;
			t2_low_q     <= '0;
			t2_high_q    <= '0;
			shift_q      <= '0;
			acr_q        <= '0;
			pcr_q        <= '0;
			flags_q      <= '0;
			enable_q     <= '0;
			t1_active_q  <= 1'b0;
			key_en_q     <= 1'b0;
			key_pend_q   <= 1'b0;
			key_byte_q   <= '0;
		end else if (fire) begin
			port_b_out_q <= port_b_out_n;
			port_a_out_q <= port_a_out_n;
			port_b_dir_q <= port_b_dir_n;
			port_a_dir_q <= port_a_dir_n;
			t1_count_q   <= t1_count_n;
			t1_latch_q   <= t1_latch_n;
			t2_low_q     <= t2_low_n;
			t2_high_q    <= t2_high_n;
			shift_q      <= shift_n;
			acr_q        <= acr_n;
			pcr_q        <= pcr_n;
			flags_q      <= flags_n;
			enable_q     <= enable_n;
			t1_active_q  <= t1_active_n;
			key_en_q     <= key_en_n;
			key_pend_q   <= key_pend_n;
			key_byte_q   <= key_byte_n;
		end
	end

	a_t1_expire: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.op == OP_TICK && t1_active_q && t1_count_q == 16'd1
		|=> flags_q[6])
		else $error("timer 1 expiry did not raise its flag");

	a_t1_start: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.op == OP_WRITE && item.reg_addr == RG_T1CH
		|=> t1_active_q && !flags_q[6])
		else $error("T1CH write did not start timer 1");

	a_key_take: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.op == OP_READ && item.reg_addr == RG_ORB && shown
		|=> !key_pend_q)
		else $error("key read did not consume the pending key");

	a_key_store: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.op == OP_KEY |=> key_pend_q && key_byte_q == $past(item.key_code))
		else $error("key press not stored");

endmodule

// ===== hw/rtl/via_style_io_timer_block_unit.sv =====
// ----------------------------------------------------------------------------
// via_style_io_timer_block_unit: 6522-style interface adapter
// Input register, step logic and result register for bus, tick and key items.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one item: op, reg_addr,
//   write_data and key_code. Output channel (out_valid/out_ready) returns
//   one result per item: read_data and irq_out, in item order.
//   An accepted item sits in the input register until it fires, is
//   applied to the adapter state and its result is registered, which
//   raises out_valid.
//   Throughput is one item per cycle while out_ready stays high; the bound
//   is the single state update per cycle in the register file.
//   When the receiver stalls with a result held, the item in the input
//   register waits and in_ready drops; in_ready follows out_ready in the
//   same cycle, so no cycle is lost when the stall ends.
//   Reset clears the input register and out_valid, not the result data,
//   and sets core registers to power-up values: timer 1 counter and
//   latch to all ones, the rest to zero, keypad disabled, no key pending.
// ----------------------------------------------------------------------------
module via_style_io_timer_block_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    op,
	input  logic [3:0]    reg_addr,
	input  logic [7:0]    write_data,
	input  logic [7:0]    key_code,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    read_data,
	output logic          irq_out
);
	import via_pkg::*;

	logic       valid_s1;
	item_t      item_s1;
	logic       fire;
	logic       out_valid_q;
	logic [7:0] read_data_q;
	logic       irq_q;
	logic [7:0] core_read;
	logic       core_irq;

	assign fire     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			item_s1 <= '0;
		else if (in_ready && in_valid)
			item_s1 <= '{op: op_t'(op), reg_addr: reg_addr,
				write_data: write_data, key_code: key_code};
	end

	via_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (item_s1),
		.read_data (core_read),
		.irq       (core_irq)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (fire)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			read_data_q <= core_read;
			irq_q       <= core_irq;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign irq_out   = irq_q;

endmodule
